// ===== design/binary_heap_priority_queue_assert.svh =====
// Assertion macros used by the priority queue top level.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BHPQ_ASSERT_HOLDS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BHPQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BHPQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bhpq_pkg.sv =====
// Package with types, codes and helpers for the binary heap priority queue.
package bhpq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_W         = 32;
    localparam int PAY_W         = 32;
    localparam int ENT_W         = KEY_W + PAY_W;
    localparam int CMD_W         = 2;
    localparam int ERR_W         = 2;
    localparam int ENTRY_COUNT_W = 7;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 80;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INS_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DEL_EMPTY = 2'd2;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic [KEY_W-1:0] top_key;
        logic [PAY_W-1:0] top_payload;
        logic [ERR_W-1:0] err;
    } res_t;

    // True when key a sorts strictly ahead of key b in the selected order.
    function automatic logic ahead(input logic largest_first,
                                   input logic [KEY_W-1:0] a,
                                   input logic [KEY_W-1:0] b);
        return largest_first ? (a > b) : (a < b);
    endfunction

endpackage

// ===== design/bhpq_mem.sv =====
// Heap entry store: one write port, two registered read ports.
module bhpq_mem #(
    parameter int DEPTH = bhpq_pkg::DEPTH_DEF,
    parameter int WIDTH = bhpq_pkg::ENT_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    import bhpq_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge aclk) begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== design/bhpq_core.sv =====
// Heap controller: command decode and the sift-up and sift-down sequencer.
module bhpq_core #(
    parameter int DEPTH = bhpq_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bhpq_pkg::CMD_W-1:0]   s_cmd,
    input  bhpq_pkg::entry_t             s_ent,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bhpq_pkg::res_t               res,
    output logic [$clog2(DEPTH+1)-1:0]   res_count,
    output logic                         mem_we,
    output logic [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic [bhpq_pkg::ENT_W-1:0]   mem_wdata,
    output logic [$clog2(DEPTH)-1:0]     mem_raddr_a,
    output logic [$clog2(DEPTH)-1:0]     mem_raddr_b,
    input  logic [bhpq_pkg::ENT_W-1:0]   mem_rdata_a,
    input  logic [bhpq_pkg::ENT_W-1:0]   mem_rdata_b
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_DN_LOAD = 3'd2;
    localparam logic [2:0] S_DN      = 3'd3;
    localparam logic [2:0] S_WR_X    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    pos_reg, pos_next;
    entry_t           ent_reg, ent_next;
    logic [ERR_W-1:0] err_reg, err_next;
    entry_t           top_reg;
    logic             lf_reg;

    entry_t        rd_a;
    entry_t        rd_b;
    entry_t        wr_ent;
    entry_t        cur_pick;
    logic [AW-1:0] up_parent;
    logic [IW-1:0] child_l;
    logic [IW-1:0] child_r;
    logic [IW-1:0] next_l;
    logic [IW-1:0] next_r;
    logic          pick_l;
    logic          pick_r;

    assign rd_a = entry_t'(mem_rdata_a);
    assign rd_b = entry_t'(mem_rdata_b);

    // Tree neighbors of the current position.
    assign up_parent = AW'((pos_reg - AW'(1)) >> 1);
    assign child_l   = {1'b0, pos_reg, 1'b1};
    assign child_r   = child_l + IW'(1);
    assign next_l    = {1'b0, pos_next, 1'b1};
    assign next_r    = next_l + IW'(1);

    // Sift-down choice: left child first, then right against the current pick.
    assign pick_l   = (child_l < IW'(count_reg)) && !ahead(lf_reg, ent_reg.key, rd_a.key);
    assign cur_pick = pick_l ? rd_a : ent_reg;
    assign pick_r   = (child_r < IW'(count_reg)) && !ahead(lf_reg, cur_pick.key, rd_b.key);

    // Sequencer next-state and memory access logic.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        ent_next    = ent_reg;
        err_next    = err_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        wr_ent      = ent_reg;
        mem_raddr_a = next_l[AW-1:0];
        mem_raddr_b = next_r[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    err_next = ERR_NONE;
                    case (s_cmd)
                        CMD_INSERT: begin
                            if (count_reg == CW'(DEPTH)) begin
                                err_next   = ERR_INS_FULL;
                                state_next = S_DONE;
                            end else begin
                                ent_next    = s_ent;
                                pos_next    = count_reg[AW-1:0];
                                count_next  = count_reg + CW'(1);
                                mem_raddr_a = AW'((count_reg[AW-1:0] - AW'(1)) >> 1);
                                state_next  = (count_reg == '0) ? S_WR_X : S_UP;
                            end
                        end
                        CMD_DELETE: begin
                            if (count_reg == '0) begin
                                err_next   = ERR_DEL_EMPTY;
                                state_next = S_DONE;
                            end else begin
                                count_next  = count_reg - CW'(1);
                                mem_raddr_a = AW'(count_reg - CW'(1));
                                state_next  = (count_reg == CW'(1)) ? S_DONE : S_DN_LOAD;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                // Move the parent down while the new entry beats it.
                mem_we = 1'b1;
                if (ahead(lf_reg, ent_reg.key, rd_a.key)) begin
                    wr_ent      = rd_a;
                    pos_next    = up_parent;
                    mem_raddr_a = AW'((up_parent - AW'(1)) >> 1);
                    state_next  = (up_parent == '0) ? S_WR_X : S_UP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_LOAD: begin
                // The former last entry travels down from the root.
                ent_next   = rd_a;
                pos_next   = '0;
                state_next = S_DN;
            end
            S_DN: begin
                mem_we = 1'b1;
                if (pick_r) begin
                    wr_ent   = rd_b;
                    pos_next = child_r[AW-1:0];
                end else if (pick_l) begin
                    wr_ent   = rd_a;
                    pos_next = child_l[AW-1:0];
                end else begin
                    state_next = S_DONE;
                end
            end
            S_WR_X: begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_wdata = wr_ent;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lf_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                lf_reg <= cfg_wr_data;
            end
        end
    end

    // Working registers; the root copy follows every write to entry zero.
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        ent_reg <= ent_next;
        err_reg <= err_next;
        if (mem_we && mem_waddr == '0) begin
            top_reg <= wr_ent;
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.top_key     = (count_reg != '0) ? top_reg.key : '0;
    assign res.top_payload = (count_reg != '0) ? top_reg.payload : '0;
    assign res.err         = err_reg;
    assign res_count       = count_reg;

endmodule

// ===== design/binary_heap_priority_queue.sv =====
// Top level of the binary heap priority queue with its output register.
//
// Channels: s_tdata carries one command word (insert, delete top, peek); every
// accepted word yields exactly one m_tdata word with the root entry, the entry
// count, a not-empty flag and an error code. A one-bit register written through
// cfg_wr_en / cfg_wr_data picks min-heap (0) or max-heap (1) order; write it only
// while the queue is idle.
// The sift moves at most log2 of DEPTH entries, one per tree level. Each
// level is one read-compare-write pass through the entry memory, whose two read
// ports fetch both children of a node at once; that memory port sets the pace.
// A finished result waits in the sequencer until the output register takes it,
// and the next word can be accepted while that register still holds the result.
// If m_tready stays low, the sequencer finishes one more word and then holds,
// and s_tready stays low until the output register frees up.
// Reset (aresetn low, synchronous) empties the queue and selects min order;
// memory contents are not cleared, as only entries below the count are read.
module binary_heap_priority_queue #(
    parameter int DEPTH = bhpq_pkg::DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] cmd, [33:2] key, [65:34] payload, [71:66] zero
    input  logic [bhpq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] top_key, [63:32] top_payload, [64] not_empty,
    // [71:65] entry_count, [73:72] error, [79:74] zero
    output logic [bhpq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import bhpq_pkg::*;

    `include "binary_heap_priority_queue_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t                 s_ent;
    res_t                   res;
    logic                   res_valid;
    logic                   res_ready;
    logic [CW-1:0]          res_count;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [ENT_W-1:0]       mem_wdata;
    logic [AW-1:0]          mem_raddr_a;
    logic [AW-1:0]          mem_raddr_b;
    logic [ENT_W-1:0]       mem_rdata_a;
    logic [ENT_W-1:0]       mem_rdata_b;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    assign s_ent.key     = s_tdata[33:2];
    assign s_ent.payload = s_tdata[65:34];

    bhpq_core #(
        .DEPTH(DEPTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_cmd       (s_tdata[1:0]),
        .s_ent       (s_ent),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .res_count   (res_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    bhpq_mem #(
        .DEPTH(DEPTH),
        .WIDTH(ENT_W)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {6'b0, res.err, ENTRY_COUNT_W'(res_count),
                            (res_count != '0), res.top_payload, res.top_key};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An insert refused as full must report a full queue.
    `BHPQ_ASSERT_IMP(a_full_err_count, res_valid && res.err == ERR_INS_FULL, res_count == CW'(DEPTH), "insert error while not full")
    // A delete refused as empty must report an empty queue.
    `BHPQ_ASSERT_IMP(a_empty_err_count, res_valid && res.err == ERR_DEL_EMPTY, res_count == '0, "delete error while not empty")
    // A finished result waits in the sequencer until the output register takes it.
    `BHPQ_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped before transfer")
    // No new word is taken while the sequencer still holds a result.
    `BHPQ_ASSERT_HOLDS(a_no_accept_busy, !(s_tready && res_valid), "input accepted while busy")

endmodule
